FILE: src/m3i_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the 3x3 matrix inverse block.
// No dependencies; imported by every module under src.
package m3i_pkg;

   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int LANES          = 9;
   localparam int LIM_WIDTH      = 16;
   localparam logic [LIM_WIDTH-1:0] LIM_RESET = 16'd1;
   localparam int CSR_WIDTH      = 32;
   localparam int ADDR_WIDTH     = 3;
   localparam logic REG_SINGULAR_LIMIT = 1'b0;

   typedef struct packed {
      logic singular;
      logic negative;
   } det_flags_type;

endpackage

FILE: src/m3i_cof_lane.sv
`timescale 1ns / 1ps
// One cofactor lane: adj = pa*pb - ma*mb, products registered, then difference.
// Depends on m3i_pkg.
module m3i_cof_lane #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [ELEM_WIDTH-1:0] pa,
   input  logic signed [ELEM_WIDTH-1:0] pb,
   input  logic signed [ELEM_WIDTH-1:0] ma,
   input  logic signed [ELEM_WIDTH-1:0] mb,
   output logic signed [2*ELEM_WIDTH:0] adj
);
   import m3i_pkg::*;

   localparam int PW = 2*ELEM_WIDTH;

   logic signed [PW-1:0] pp_ff, mp_ff;
   logic signed [PW:0]   adj_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff  <= pa * pb;
         mp_ff  <= ma * mb;
         adj_ff <= $signed({pp_ff[PW-1], pp_ff}) - $signed({mp_ff[PW-1], mp_ff});
      end
   end

   assign adj = adj_ff;

endmodule

FILE: src/m3i_det.sv
`timescale 1ns / 1ps
// Determinant from the first row and its cofactors: split partial products,
// sum, then magnitude, sign and singular check. Depends on m3i_pkg.
module m3i_det #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic [m3i_pkg::LIM_WIDTH-1:0]      limit,
   input  logic signed [ELEM_WIDTH-1:0]       e0,
   input  logic signed [ELEM_WIDTH-1:0]       e1,
   input  logic signed [ELEM_WIDTH-1:0]       e2,
   input  logic signed [2*ELEM_WIDTH:0]       c0,
   input  logic signed [2*ELEM_WIDTH:0]       c1,
   input  logic signed [2*ELEM_WIDTH:0]       c2,
   output logic [3*ELEM_WIDTH+2:0]            absdet,
   output logic [3*ELEM_WIDTH+3:0]            twodet,
   output m3i_pkg::det_flags_type             flags
);
   import m3i_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int DW = 3*W+3;
   localparam int LW = (DW > LIM_WIDTH+2*FRAC_BITS) ? DW : LIM_WIDTH+2*FRAC_BITS;

   logic signed [2*W+1:0] lo_ff [3];
   logic signed [2*W-1:0] hi_ff [3];
   logic signed [DW-1:0]  det_ff;
   logic signed [DW-1:0]  lo_sum, hi_sum, det_in;
   logic [DW-1:0]         mag;
   logic [LW-1:0]         lim_sh;
   logic [DW-1:0]         absdet_ff;
   logic [DW:0]           twodet_ff;
   det_flags_type         flags_ff;

   always_comb begin
      lo_sum = DW'(lo_ff[0]) + DW'(lo_ff[1]) + DW'(lo_ff[2]);
      hi_sum = DW'(hi_ff[0]) + DW'(hi_ff[1]) + DW'(hi_ff[2]);
      det_in = lo_sum + (hi_sum <<< (W+1));
      mag    = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
      lim_sh = LW'(limit) << (2*FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff[0] <= e0 * $signed({1'b0, c0[W:0]});
         lo_ff[1] <= e1 * $signed({1'b0, c1[W:0]});
         lo_ff[2] <= e2 * $signed({1'b0, c2[W:0]});
         hi_ff[0] <= e0 * $signed(c0[2*W:W+1]);
         hi_ff[1] <= e1 * $signed(c1[2*W:W+1]);
         hi_ff[2] <= e2 * $signed(c2[2*W:W+1]);
         det_ff   <= det_in;
         absdet_ff <= mag;
         twodet_ff <= {mag, 1'b0};
         flags_ff.negative <= det_ff[DW-1];
         flags_ff.singular <= (mag == '0) || (LW'(mag) < lim_sh);
      end
   end

   assign absdet = absdet_ff;
   assign twodet = twodet_ff;
   assign flags  = flags_ff;

endmodule

FILE: src/m3i_div_lane.sv
`timescale 1ns / 1ps
// One divider lane: rounded |adj|*2^(2F)/|det|, one quotient bit per stage,
// then sign and saturation. Divisor line comes from the top. Depends on m3i_pkg.
module m3i_div_lane #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [2*ELEM_WIDTH:0] adj,
   input  logic [3*ELEM_WIDTH+2:0]      absdet,
   input  logic                         det_neg,
   input  logic [3*ELEM_WIDTH+3:0]      divisor [ELEM_WIDTH+1],
   output logic [ELEM_WIDTH-1:0]        value,
   output logic                         sat
);
   import m3i_pkg::*;

   localparam int W   = ELEM_WIDTH;
   localparam int AW  = 2*W+1;
   localparam int DW  = 3*W+3;
   localparam int NA  = AW+2*FRAC_BITS+1;
   localparam int NW  = ((NA > DW) ? NA : DW) + 1;
   localparam int CW  = (NW > DW+W+2) ? NW : DW+W+2;
   localparam int QW  = W+1;

   logic signed [AW-1:0] adj_ff [3];
   logic [CW-1:0] rem_ff [W+2];
   logic [QW-1:0] q_ff   [W+2];
   logic          neg_ff [W+2];
   logic          ovf_ff [W+2];
   logic [AW-1:0] absadj;
   logic [QW-1:0] bound, mag;
   logic          big;
   logic [W-1:0]  value_ff;
   logic          sat_ff;

   assign absadj = adj_ff[2][AW-1] ? AW'(-adj_ff[2]) : AW'(adj_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         adj_ff[0] <= adj;
         adj_ff[1] <= adj_ff[0];
         adj_ff[2] <= adj_ff[1];
         rem_ff[0] <= (CW'(absadj) << (2*FRAC_BITS+1)) + CW'(absdet);
         neg_ff[0] <= adj_ff[2][AW-1] ^ det_neg;
         q_ff[0]   <= '0;
         ovf_ff[0] <= 1'b0;
      end
   end

   for (genvar j = 0; j <= W; j++) begin : g_stage
      logic [CW-1:0] dsh;
      logic          ge;
      logic          ovf;
      assign dsh = CW'(divisor[j]) << (W-j);
      assign ge  = rem_ff[j] >= dsh;
      if (j == 0) begin : g_first
         assign ovf = rem_ff[0] >= (CW'(divisor[0]) << (W+1));
      end else begin : g_rest
         assign ovf = ovf_ff[j];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= ge ? rem_ff[j] - dsh : rem_ff[j];
            q_ff[j+1]   <= {q_ff[j][QW-2:0], ge};
            neg_ff[j+1] <= neg_ff[j];
            ovf_ff[j+1] <= ovf;
         end
      end
   end

   always_comb begin
      bound = {1'b0, neg_ff[W+1], {(W-1){~neg_ff[W+1]}}};
      big   = ovf_ff[W+1] || (q_ff[W+1] > bound);
      mag   = big ? bound : q_ff[W+1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= neg_ff[W+1] ? W'(-mag) : W'(mag);
         sat_ff   <= big;
      end
   end

   assign value = value_ff;
   assign sat   = sat_ff;

endmodule

FILE: src/matrix3_inverse_top.sv
`timescale 1ns / 1ps
// Channel  Ports                        Width        Direction
// req      req_valid/ready, req_a11..33 9 x ELEM     in
// rsp      rsp_valid/ready, rsp_inv11..33, flags     out
// csr      psel/penable/pwrite/paddr/pwdata/prdata   APB, singular_limit at 0
// One matrix per cycle while no result is stalled; the inverses are formed by the
// one-bit-per-stage dividers in the nine lanes. Reset clears the valid line and the
// limit register (to 1). A stalled result holds the whole pipeline; req_ready follows
// !rsp_valid || rsp_ready.
// Depends on m3i_pkg, the lane modules and m3i_det.
module matrix3_inverse_top #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [ELEM_WIDTH-1:0]          req_a11,
   input  logic signed [ELEM_WIDTH-1:0]          req_a12,
   input  logic signed [ELEM_WIDTH-1:0]          req_a13,
   input  logic signed [ELEM_WIDTH-1:0]          req_a21,
   input  logic signed [ELEM_WIDTH-1:0]          req_a22,
   input  logic signed [ELEM_WIDTH-1:0]          req_a23,
   input  logic signed [ELEM_WIDTH-1:0]          req_a31,
   input  logic signed [ELEM_WIDTH-1:0]          req_a32,
   input  logic signed [ELEM_WIDTH-1:0]          req_a33,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [ELEM_WIDTH-1:0]          rsp_inv11,
   output logic signed [ELEM_WIDTH-1:0]          rsp_inv12,
   output logic signed [ELEM_WIDTH-1:0]          rsp_inv13,
   output logic signed [ELEM_WIDTH-1:0]          rsp_inv21,
   output logic signed [ELEM_WIDTH-1:0]          rsp_inv22,
   output logic signed [ELEM_WIDTH-1:0]          rsp_inv23,
   output logic signed [ELEM_WIDTH-1:0]          rsp_inv31,
   output logic signed [ELEM_WIDTH-1:0]          rsp_inv32,
   output logic signed [ELEM_WIDTH-1:0]          rsp_inv33,
   output logic                                  rsp_singular,
   output logic                                  rsp_saturated,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [m3i_pkg::ADDR_WIDTH-1:0]        paddr,
   input  logic [m3i_pkg::CSR_WIDTH-1:0]         pwdata,
   output logic [m3i_pkg::CSR_WIDTH-1:0]         prdata,
   output logic                                  pready
);
   import m3i_pkg::*;

   localparam int W   = ELEM_WIDTH;
   localparam int AW  = 2*W+1;
   localparam int DW  = 3*W+3;
   localparam int LAT = W+9;
   localparam int SGD = W+3;

   logic                    en;
   logic [LAT-1:0]          vld_ff;
   logic [LIM_WIDTH-1:0]    limit_ff;
   logic signed [W-1:0]     elem [LANES];
   logic signed [W-1:0]     edly_ff [2][3];
   logic signed [AW-1:0]    adj [LANES];
   logic [DW-1:0]           absdet;
   logic [DW:0]             twodet;
   det_flags_type           flags;
   logic [DW:0]             dv_ff [W+1];
   logic                    sing_ff [SGD];
   logic [W-1:0]            lane_val [LANES];
   logic [LANES-1:0]        lane_sat;
   logic [W-1:0]            inv_ff [LANES];
   logic                    sing_out_ff, sat_out_ff;
   logic                    reg_sel;

   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT-1];
   assign pready    = 1'b1;
   assign reg_sel   = paddr[ADDR_WIDTH-1] == REG_SINGULAR_LIMIT;
   assign prdata    = reg_sel ? CSR_WIDTH'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIM_RESET;
         vld_ff   <= '0;
      end else begin
         if (psel && penable && pwrite && reg_sel) begin
            limit_ff <= pwdata[LIM_WIDTH-1:0];
         end
         if (en) begin
            vld_ff <= {vld_ff[LAT-2:0], req_valid};
         end
      end
   end

   assign elem = '{req_a11, req_a12, req_a13, req_a21, req_a22, req_a23,
                   req_a31, req_a32, req_a33};

   // cofactor lanes, adjugate in row-major order
   localparam int PA [LANES] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
   localparam int PB [LANES] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
   localparam int MA [LANES] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
   localparam int MB [LANES] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

   for (genvar i = 0; i < LANES; i++) begin : g_cof
      m3i_cof_lane #(.ELEM_WIDTH(W)) u_cof (
         .clock (clock),
         .en    (en),
         .pa    (elem[PA[i]]),
         .pb    (elem[PB[i]]),
         .ma    (elem[MA[i]]),
         .mb    (elem[MB[i]]),
         .adj   (adj[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         edly_ff[0] <= '{elem[0], elem[1], elem[2]};
         edly_ff[1] <= edly_ff[0];
      end
   end

   m3i_det #(.ELEM_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_det (
      .clock  (clock),
      .en     (en),
      .limit  (limit_ff),
      .e0     (edly_ff[1][0]),
      .e1     (edly_ff[1][1]),
      .e2     (edly_ff[1][2]),
      .c0     (adj[0]),
      .c1     (adj[3]),
      .c2     (adj[6]),
      .absdet (absdet),
      .twodet (twodet),
      .flags  (flags)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0]   <= twodet;
         sing_ff[0] <= flags.singular;
         for (int k = 1; k <= W; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         for (int k = 1; k < SGD; k++) begin
            sing_ff[k] <= sing_ff[k-1];
         end
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_div
      m3i_div_lane #(.ELEM_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
         .clock   (clock),
         .en      (en),
         .adj     (adj[i]),
         .absdet  (absdet),
         .det_neg (flags.negative),
         .divisor (dv_ff),
         .value   (lane_val[i]),
         .sat     (lane_sat[i])
      );
   end

   // merge: singular forces zeros and clears saturation, which is otherwise any lane clamping
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            inv_ff[i] <= sing_ff[SGD-1] ? '0 : lane_val[i];
         end
         sing_out_ff <= sing_ff[SGD-1];
         sat_out_ff  <= !sing_ff[SGD-1] && (|lane_sat);
      end
   end

   assign rsp_inv11     = inv_ff[0];
   assign rsp_inv12     = inv_ff[1];
   assign rsp_inv13     = inv_ff[2];
   assign rsp_inv21     = inv_ff[3];
   assign rsp_inv22     = inv_ff[4];
   assign rsp_inv23     = inv_ff[5];
   assign rsp_inv31     = inv_ff[6];
   assign rsp_inv32     = inv_ff[7];
   assign rsp_inv33     = inv_ff[8];
   assign rsp_singular  = sing_out_ff;
   assign rsp_saturated = sat_out_ff;

   a_sing_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_saturated)
      else $error("singular result flagged saturated");

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_inv11 == '0 && rsp_inv22 == '0 && rsp_inv33 == '0)
      else $error("singular result not zero");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inv11) && $stable(rsp_singular))
      else $error("stalled result changed");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for matrix3_inverse_top: random and directed 3x3 matrices, with an
// exact wide-integer inverse predictor. Depends on m3i_pkg and the RTL under src.
module tb;
   import m3i_pkg::*;

   localparam int EW = ELEM_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = EW + 9;

   typedef logic signed [EW-1:0] elem_type;
   typedef struct {
      elem_type a [9];
   } matrix_type;
   typedef struct {
      elem_type inv [9];
      logic singular;
      logic saturated;
   } inverse_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   elem_type req_a [9];
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   elem_type rsp_inv [9];
   logic rsp_singular, rsp_saturated;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_WIDTH-1:0] pwdata = '0;
   logic [CSR_WIDTH-1:0] prdata;
   logic pready;

   matrix_type pending_mats [$];
   inverse_type expected_inverses [$];
   logic [LIM_WIDTH-1:0] limit_model = LIM_RESET;
   int errors = 0;
   int n_sent = 0, n_checked = 0, n_singular = 0, n_sat = 0;
   bit quiet = 1'b0;
   int send_gap = 0, recv_gap = 0;

   initial for (int i = 0; i < 9; i++) req_a[i] = '0;

   always #4 clock = ~clock;

   matrix3_inverse_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a11(req_a[0]), .req_a12(req_a[1]), .req_a13(req_a[2]),
      .req_a21(req_a[3]), .req_a22(req_a[4]), .req_a23(req_a[5]),
      .req_a31(req_a[6]), .req_a32(req_a[7]), .req_a33(req_a[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_inv11(rsp_inv[0]), .rsp_inv12(rsp_inv[1]), .rsp_inv13(rsp_inv[2]),
      .rsp_inv21(rsp_inv[3]), .rsp_inv22(rsp_inv[4]), .rsp_inv23(rsp_inv[5]),
      .rsp_inv31(rsp_inv[6]), .rsp_inv32(rsp_inv[7]), .rsp_inv33(rsp_inv[8]),
      .rsp_singular(rsp_singular), .rsp_saturated(rsp_saturated),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // exact inverse: cofactors and determinant in 200-bit signed arithmetic
   function automatic inverse_type invert(matrix_type m, logic [LIM_WIDTH-1:0] lim);
      inverse_type r;
      logic signed [199:0] e [9];
      logic signed [199:0] adj [9];
      logic signed [199:0] det, absdet, num, q, bound;
      logic [199:0] lim_w;
      bit neg;
      for (int i = 0; i < 9; i++) e[i] = m.a[i];
      adj[0] = e[4]*e[8] - e[7]*e[5];
      adj[1] = e[7]*e[2] - e[1]*e[8];
      adj[2] = e[1]*e[5] - e[4]*e[2];
      adj[3] = e[6]*e[5] - e[3]*e[8];
      adj[4] = e[0]*e[8] - e[6]*e[2];
      adj[5] = e[3]*e[2] - e[0]*e[5];
      adj[6] = e[3]*e[7] - e[6]*e[4];
      adj[7] = e[6]*e[1] - e[0]*e[7];
      adj[8] = e[0]*e[4] - e[3]*e[1];
      det = e[0]*adj[0] + e[1]*adj[3] + e[2]*adj[6];
      absdet = det < 0 ? -det : det;
      lim_w = 200'(lim) << (2*FB);
      r.singular = 1'b0;
      r.saturated = 1'b0;
      for (int i = 0; i < 9; i++) r.inv[i] = '0;
      if (absdet == 0 || $unsigned(absdet) < lim_w) begin
         r.singular = 1'b1;
         return r;
      end
      for (int i = 0; i < 9; i++) begin
         neg = (adj[i] < 0) != (det < 0);
         num = (adj[i] < 0 ? -adj[i] : adj[i]) << (2*FB + 1);
         q = $signed($unsigned(num + absdet) / $unsigned(absdet << 1));
         bound = (200'sd1 <<< (EW-1)) - (neg ? 0 : 1);
         if (q > bound) begin
            q = bound;
            r.saturated = 1'b1;
         end
         r.inv[i] = elem_type'(neg ? -q : q);
      end
      return r;
   endfunction

   task automatic report(string what, int idx, logic [EW-1:0] got, logic [EW-1:0] want);
      errors++;
      $display("MISMATCH item %0d %s: got %h expected %h", idx, what, got, want);
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            n_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_mats.size() > 0) begin
               matrix_type m;
               m = pending_mats.pop_front();
               for (int i = 0; i < 9; i++) req_a[i] <= m.a[i];
               expected_inverses.push_back(invert(m, limit_model));
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_inverses.size() == 0) begin
               report("unexpected item", n_checked, '0, '0);
            end else begin
               inverse_type w;
               w = expected_inverses.pop_front();
               for (int i = 0; i < 9; i++)
                  if (rsp_inv[i] !== w.inv[i])
                     report($sformatf("inv%0d%0d", i/3 + 1, i%3 + 1), n_checked,
                            rsp_inv[i], w.inv[i]);
               if (rsp_singular !== w.singular)
                  report("singular", n_checked, EW'(rsp_singular), EW'(w.singular));
               if (rsp_saturated !== w.saturated)
                  report("saturated", n_checked, EW'(rsp_saturated), EW'(w.saturated));
               n_singular += w.singular;
               n_sat += w.saturated;
            end
            n_checked++;
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 7);
         end
      end
   end

   // matrices as created here take effect when the driver issues them
   function automatic elem_type rand_elem(int kind);
      case (kind)
         0: return elem_type'($urandom);
         1: return elem_type'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
         2: return elem_type'($signed($urandom_range(0, 1 << 10)) - (1 << 9));
         default: begin
            case ($urandom_range(0, 4))
               0: return elem_type'(32'h7fffffff);
               1: return elem_type'(32'h80000000);
               2: return elem_type'(1 << FB);
               3: return '0;
               default: return elem_type'(-1);
            endcase
         end
      endcase
   endfunction

   task automatic add_mat(elem_type a0, elem_type a1, elem_type a2, elem_type a3,
                          elem_type a4, elem_type a5, elem_type a6, elem_type a7,
                          elem_type a8);
      matrix_type m;
      m.a = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
      pending_mats.push_back(m);
   endtask

   task automatic add_random(int n);
      matrix_type m;
      int kind;
      for (int k = 0; k < n; k++) begin
         kind = $urandom_range(0, 9);
         for (int i = 0; i < 9; i++)
            m.a[i] = rand_elem(kind < 2 ? 0 : kind < 6 ? 1 : kind < 8 ? 2
                               : $urandom_range(0, 3));
         // occasionally copy one row into another for an exactly zero determinant
         if ($urandom_range(0, 15) == 0)
            for (int i = 0; i < 3; i++) m.a[6 + i] = m.a[i];
         pending_mats.push_back(m);
      end
   endtask

   task automatic drain();
      while (pending_mats.size() > 0 || expected_inverses.size() > 0 || req_valid)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic csr_write(logic [LIM_WIDTH-1:0] value);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_WIDTH'(REG_SINGULAR_LIMIT) << 2;
      pwdata <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      limit_model = value;
      @(posedge clock);
   endtask

   localparam elem_type ONE = 1 << FB;
   localparam elem_type MAXV = 32'h7fffffff;
   localparam elem_type MINV = 32'h80000000;

   initial begin
      logic [LIM_WIDTH-1:0] limits [4];
      limits = '{16'd0, 16'hffff, 16'd1, 16'd300};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: identity, scaled, zero, extremes, rank-deficient, near-singular, ties
      add_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
      add_mat(2*ONE, 0, 0, 0, -4*ONE, 0, 0, 0, ONE/2);
      add_mat(0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_mat(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV);
      add_mat(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV);
      add_mat(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV);
      add_mat(1, 0, 0, 0, 1, 0, 0, 0, 1);
      add_mat(-1, 0, 0, 0, -1, 0, 0, 0, -1);
      add_mat(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE);
      add_mat(3*ONE, 0, 0, 0, 3*ONE, 0, 0, 0, 3*ONE);
      add_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, 1 << 12);
      add_mat(1 << 12, 0, 0, 0, 1 << 12, 0, 0, 0, 1 << 12);
      add_mat(4*ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
      add_mat(ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE);
      add_mat(MINV, 0, 0, 0, ONE, 0, 0, 0, ONE);
      add_mat(-ONE, 5, 7, -3, ONE, 2, 9, -8, -ONE);
      drain();
      for (int p = 0; p < 4; p++) begin
         csr_write(limits[p]);
         add_random(300);
         drain();   // sender holds off until all results are back
      end
      csr_write(16'd1);
      add_random(200);
      while (pending_mats.size() > 0) @(posedge clock);
      quiet = 1'b1;
      add_random(250);
      drain();
      $display("Checked %0d inverses (%0d singular, %0d saturated) over five limit settings.",
               n_checked, n_singular, n_sat);
      if (errors == 0 && expected_inverses.size() == 0)
         $display("matrix3_inverse_top regression: pass");
      else
         $display("matrix3_inverse_top regression: fail");
      $finish;
   end

   initial begin
      #5ms;
      $display("matrix3_inverse_top regression: fail");
      $finish;
   end
endmodule
